@@ sv/clgt_pkg.sv @@
// Package for the client gateway learning table.
// Request and response type codes, field widths and the staged request struct.
// No dependencies.
`timescale 1ns / 1ps

package clgt_pkg;

   localparam int unsigned ADDR_W      = 32;
   localparam int unsigned REQ_DATA_W  = 64;  // client, gateway
   localparam int unsigned RSP_DATA_W  = 40;  // found, drop, next hop, full, pad

   // Request kind, carried on tuser of both channels
   typedef enum logic [0:0] {
      KIND_LOOKUP = 1'b0,
      KIND_LEARN  = 1'b1
   } kind_type;

   // Request as held in the input register
   typedef struct packed {
      kind_type            kind;
      logic [ADDR_W-1:0]   client;
      logic [ADDR_W-1:0]   gateway;
   } req_type;

   // Result fields before packing onto the response bus
   typedef struct packed {
      kind_type            kind;
      logic                found;
      logic                drop;
      logic [ADDR_W-1:0]   next_hop;
      logic                full;
   } rsp_type;

endpackage

@@ sv/client_gateway_learning_table_top.sv @@
// Client gateway learning table, top level.
// Fully associative client-to-gateway table with stream request/response channels.
// Depends on clgt_pkg.
`timescale 1ns / 1ps

// Maps a client IPv4 address to the access-point address it was last seen
// behind. A lookup transaction (tuser = 0) returns the stored gateway as the
// next hop, or flags drop_packet on a miss. A learn transaction (tuser = 1)
// overwrites the gateway of a known client, or stores a new client in the
// lowest free entry; with no free entry it sets table_full and stores
// nothing. Every request gives exactly one response, in order. The block
// takes one transaction per cycle while the response side does not stall
// it. The request is held in the input register while the all-entry
// parallel compare feeds the response register, which drives rsp_tvalid.
// The table update lands at the same edge as the response register load,
// so the next request already sees it. Back-pressure on the response side
// stalls both stages. Reset clears all valid bits at once.
module client_gateway_learning_table_top #(
   parameter int unsigned ENTRIES = 16   // table depth, 2 .. 256
) (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [clgt_pkg::REQ_DATA_W-1:0] req_tdata,  // [31:0] client_addr,
                                                       // [63:32] gateway_addr
   input  logic                          req_tuser,  // [0] req_type
   // response channel
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [clgt_pkg::RSP_DATA_W-1:0] rsp_tdata,  // [0] found, [1] drop_packet,
                                                       // [33:2] next_hop_addr,
                                                       // [34] table_full, [39:35] zero
   output logic                          rsp_tuser   // [0] kind_echo
);
   import clgt_pkg::*;

   // ---------------------------------------------------------------
   // Stage control: response register frees when empty or taken
   // ---------------------------------------------------------------
   logic    s1_vld_ff, s1_vld_in;
   req_type s1_req_ff, s1_req_in;
   logic    out_vld_ff, out_vld_in;
   rsp_type out_rsp_ff, out_rsp_in;
   logic    advance;

   assign advance    = !out_vld_ff || rsp_tready;
   assign req_tready = !s1_vld_ff || advance;

   // ---------------------------------------------------------------
   // Table storage: one register row per entry
   // ---------------------------------------------------------------
   logic [ADDR_W-1:0]  ent_client_ff  [ENTRIES];
   logic [ADDR_W-1:0]  ent_gateway_ff [ENTRIES];
   logic [ENTRIES-1:0] ent_valid_ff, ent_valid_in;

   logic [ENTRIES-1:0] hit_vec;      // raw compare hits
   logic [ENTRIES-1:0] hit_first;    // lowest hit, one-hot
   logic [ENTRIES-1:0] free_first;   // lowest free entry, one-hot
   logic [ENTRIES-1:0] wr_client;    // entry takes new client
   logic [ENTRIES-1:0] wr_gateway;   // entry takes new gateway
   logic               any_hit;
   logic               any_free;
   logic [ADDR_W-1:0]  hit_gateway;
   logic               s1_fire;

   assign s1_fire = s1_vld_ff && advance;

   // parallel compare, then lowest-index pick for hits and free slots
   always_comb begin
      logic seen_hit;
      logic seen_free;
      seen_hit    = 1'b0;
      seen_free   = 1'b0;
      hit_gateway = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         hit_vec[i]    = ent_valid_ff[i] && (ent_client_ff[i] == s1_req_ff.client);
         hit_first[i]  = hit_vec[i] && !seen_hit;
         free_first[i] = !ent_valid_ff[i] && !seen_free;
         seen_hit      = seen_hit || hit_vec[i];
         seen_free     = seen_free || !ent_valid_ff[i];
         hit_gateway   = hit_gateway | (ent_gateway_ff[i] & {ADDR_W{hit_first[i]}});
      end
      any_hit  = seen_hit;
      any_free = seen_free;
   end

   // write enables
   always_comb begin
      logic learn;
      learn = s1_fire && (s1_req_ff.kind == KIND_LEARN);
      for (int i = 0; i < ENTRIES; i++) begin
         wr_client[i]  = learn && !any_hit && free_first[i];
         wr_gateway[i] = learn && (any_hit ? hit_first[i] : free_first[i]);
      end
      ent_valid_in = ent_valid_ff | wr_client;
   end

   // result fields
   always_comb begin
      out_rsp_in          = '0;
      out_rsp_in.kind     = s1_req_ff.kind;
      out_rsp_in.found    = any_hit;
      if (s1_req_ff.kind == KIND_LOOKUP) begin
         out_rsp_in.drop     = !any_hit;
         out_rsp_in.next_hop = hit_gateway;
      end else begin
         out_rsp_in.full     = !any_hit && !any_free;
      end
   end

   // input register next values
   always_comb begin
      s1_vld_in = s1_vld_ff;
      s1_req_in = s1_req_ff;
      if (req_tready) begin
         s1_vld_in         = req_tvalid;
         s1_req_in.kind    = kind_type'(req_tuser);
         s1_req_in.client  = req_tdata[ADDR_W-1:0];
         s1_req_in.gateway = req_tdata[2*ADDR_W-1:ADDR_W];
      end
   end

   assign out_vld_in = advance ? s1_vld_ff : out_vld_ff;

   // ---------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff    <= 1'b0;
         out_vld_ff   <= 1'b0;
         ent_valid_ff <= '0;
      end else begin
         s1_vld_ff    <= s1_vld_in;
         out_vld_ff   <= out_vld_in;
         ent_valid_ff <= ent_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_req_ff <= s1_req_in;
      if (s1_fire) begin
         out_rsp_ff <= out_rsp_in;
      end
      for (int i = 0; i < ENTRIES; i++) begin
         if (wr_client[i]) begin
            ent_client_ff[i] <= s1_req_ff.client;
         end
         if (wr_gateway[i]) begin
            ent_gateway_ff[i] <= s1_req_ff.gateway;
         end
      end
   end

   // ---------------------------------------------------------------
   // Response packing
   // ---------------------------------------------------------------
   assign rsp_tvalid = out_vld_ff;
   assign rsp_tuser  = out_rsp_ff.kind;
   assign rsp_tdata  = {{(RSP_DATA_W - ADDR_W - 3){1'b0}},
                        out_rsp_ff.full,
                        out_rsp_ff.next_hop,
                        out_rsp_ff.drop,
                        out_rsp_ff.found};

   // ---------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------
   // a client never sits in two entries
   a_no_dup: assert property (@(posedge clock) disable iff (reset)
      s1_vld_ff |-> $onehot0(hit_vec))
      else $error("duplicate client entries");

   // full flag only on learn, drop only on lookup
   a_full_learn: assert property (@(posedge clock) disable iff (reset)
      (out_vld_ff && out_rsp_ff.full) |-> (out_rsp_ff.kind == KIND_LEARN))
      else $error("table_full on lookup");

   a_drop_lookup: assert property (@(posedge clock) disable iff (reset)
      (out_vld_ff && out_rsp_ff.drop) |->
         (out_rsp_ff.kind == KIND_LOOKUP && !out_rsp_ff.found))
      else $error("bad drop flag");

   // a full report means every entry was in use
   a_full_all: assert property (@(posedge clock) disable iff (reset)
      (s1_fire && out_rsp_in.full) |-> (&ent_valid_ff))
      else $error("table_full with free entry");

   // valid bits only ever get set, one per learn at most
   a_valid_grow: assert property (@(posedge clock) disable iff (reset)
      $countones(wr_client) <= 1)
      else $error("multiple entries allocated");

endmodule

@@ test/clgt_route_checker.sv @@
// Response checker for the client gateway learning table.
// Keeps a shadow table, predicts each response and compares it on the response channel.
// Depends on clgt_pkg.
`timescale 1ns / 1ps

module clgt_route_checker #(
   parameter int unsigned ENTRIES = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   input  logic                             req_tready,
   input  logic [clgt_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  logic                             req_tuser,
   input  logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   input  logic [clgt_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input  logic                             rsp_tuser,
   output int unsigned                      mismatches,
   output int unsigned                      awaited,
   output int unsigned                      replies_checked
);
   import clgt_pkg::*;

   logic [ADDR_W-1:0] shadow_client  [ENTRIES];
   logic [ADDR_W-1:0] shadow_gateway [ENTRIES];
   logic              shadow_valid   [ENTRIES];
   rsp_type           awaited_replies[$];
   int unsigned       err_count;
   int unsigned       done_count;

   // Applies one request to the shadow table and returns the response it must give.
   function automatic rsp_type resolve_request(kind_type kind, logic [ADDR_W-1:0] client,
                                               logic [ADDR_W-1:0] gateway);
      rsp_type r;
      int      hit;
      int      free_slot;
      r         = '0;
      r.kind    = kind;
      hit       = -1;
      free_slot = -1;
      // walk downward so the lowest matching / free index is the one kept
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (shadow_valid[i] && shadow_client[i] == client) hit = i;
         if (!shadow_valid[i]) free_slot = i;
      end
      if (kind == KIND_LOOKUP) begin
         if (hit >= 0) begin
            r.found    = 1'b1;
            r.next_hop = shadow_gateway[hit];
         end else begin
            r.drop = 1'b1;
         end
      end else if (hit >= 0) begin
         r.found             = 1'b1;
         shadow_gateway[hit] = gateway;
      end else if (free_slot >= 0) begin
         shadow_client[free_slot]  = client;
         shadow_gateway[free_slot] = gateway;
         shadow_valid[free_slot]   = 1'b1;
      end else begin
         r.full = 1'b1;
      end
      return r;
   endfunction

   always @(posedge clock) begin
      rsp_type got;
      rsp_type want;
      logic [4:0] pad;
      if (reset) begin
         awaited_replies.delete();
         foreach (shadow_valid[i]) shadow_valid[i] = 1'b0;
         err_count  = 0;
         done_count = 0;
      end else begin
         // response first: it is always older than a request taken at the same edge
         if (rsp_tvalid && rsp_tready) begin
            got.kind     = kind_type'(rsp_tuser);
            got.found    = rsp_tdata[0];
            got.drop     = rsp_tdata[1];
            got.next_hop = rsp_tdata[33:2];
            got.full     = rsp_tdata[34];
            pad          = rsp_tdata[39:35];
            done_count++;
            if (awaited_replies.size() == 0) begin
               if (err_count < 10)
                  $display("%0t: response with no request outstanding: tuser=%b tdata=%h",
                           $realtime, rsp_tuser, rsp_tdata);
               err_count++;
            end else begin
               want = awaited_replies.pop_front();
               if (got !== want || pad !== 5'd0) begin
                  if (err_count < 10) begin
                     $display("%0t: response %0d mismatch", $realtime, done_count);
                     $display("   expected kind=%0d found=%b drop=%b hop=%h full=%b pad=00",
                              want.kind, want.found, want.drop, want.next_hop, want.full);
                     $display("   actual   kind=%0d found=%b drop=%b hop=%h full=%b pad=%h",
                              got.kind, got.found, got.drop, got.next_hop, got.full, pad);
                  end
                  err_count++;
               end
            end
         end
         if (req_tvalid && req_tready)
            awaited_replies.push_back(resolve_request(kind_type'(req_tuser),
                                                      req_tdata[31:0], req_tdata[63:32]));
      end
      mismatches      <= err_count;
      awaited         <= awaited_replies.size();
      replies_checked <= done_count;
   end

endmodule

@@ test/tb_top.sv @@
// Testbench top for the client gateway learning table.
// Drives requests and response back-pressure, gives the verdict; checking is in clgt_route_checker.
// Depends on clgt_pkg, client_gateway_learning_table_top and clgt_route_checker.
`timescale 1ns / 1ps

module tb_top;
   import clgt_pkg::*;

   localparam int unsigned ENTRIES      = 16;
   localparam int unsigned RANDOM_ITEMS = 1125;
   // worst quiet stretch: sender gap + receiver stall + the block's two stages;
   // taken many times over
   localparam int unsigned IDLE_LIMIT   = 2000;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  req_tuser  = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;

   int unsigned mismatches;
   int unsigned awaited;
   int unsigned replies_checked;

   bit          send_burst  = 1'b0;   // sender runs back-to-back while set
   bit          rsp_burst   = 1'b0;   // receiver never stalls while set
   int unsigned stall_left  = 0;
   int unsigned rsp_count   = 0;
   int unsigned idle_cycles = 0;
   int unsigned n_lookup    = 0;
   int unsigned n_learn     = 0;

   // Clients the table should hold; used only to steer stimulus toward hits
   // and overwrites. Entries are never freed, so this list only grows.
   logic [ADDR_W-1:0] known_clients[$];

   always #5 clock = ~clock;

   client_gateway_learning_table_top #(
      .ENTRIES (ENTRIES)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   clgt_route_checker #(
      .ENTRIES (ENTRIES)
   ) i_checker (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tuser       (req_tuser),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tuser       (rsp_tuser),
      .mismatches      (mismatches),
      .awaited         (awaited),
      .replies_checked (replies_checked)
   );

   function automatic bit is_known(logic [ADDR_W-1:0] addr);
      foreach (known_clients[i])
         if (known_clients[i] == addr) return 1'b1;
      return 1'b0;
   endfunction

   // A client address the table has never seen
   function automatic logic [ADDR_W-1:0] fresh_client();
      logic [ADDR_W-1:0] addr;
      do addr = $urandom; while (is_known(addr));
      return addr;
   endfunction

   // Gateway with the all-zero and all-one extremes mixed in
   function automatic logic [ADDR_W-1:0] pick_gateway();
      int unsigned sel;
      sel = $urandom_range(0, 9);
      if (sel == 0) return '0;
      if (sel == 1) return '1;
      return $urandom;
   endfunction

   // One request transaction: optional idle gap, then hold tvalid until accepted.
   // tvalid stays high on return so back-to-back transactions need no idle gap between them.
   task automatic send_req(kind_type kind, logic [ADDR_W-1:0] client,
                           logic [ADDR_W-1:0] gateway);
      int unsigned gap;
      gap = send_burst ? 0 : $urandom_range(0, 11);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {gateway, client};
      do @(posedge clock); while (!req_tready);
      if (kind == KIND_LEARN) begin
         n_learn++;
         if (!is_known(client) && known_clients.size() < ENTRIES)
            known_clients.push_back(client);
      end else begin
         n_lookup++;
      end
   endtask

   // Stop sending and wait until every outstanding response has come back.
   // The first edge lets the checker count the transaction accepted just now.
   task automatic drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (awaited != 0);
   endtask

   // Response back-pressure: after each accepted response, rsp_tready may drop for a
   // randomly drawn stall; in burst stretches the receiver is always ready.
   always @(posedge clock) begin
      int unsigned wait_cycles;
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left <= 0;
      end else if (rsp_tvalid && rsp_tready) begin
         rsp_count++;
         if (rsp_count % 50 == 0) rsp_burst = ($urandom_range(0, 3) == 0);
         wait_cycles = rsp_burst ? 0 : $urandom_range(0, 11);
         stall_left <= wait_cycles;
         rsp_tready <= (wait_cycles == 0);
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= (stall_left == 1);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Watchdog: a long run of cycles with no transaction on either channel
   // means the block has hung.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == IDLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      logic [ADDR_W-1:0] client;
      int unsigned       roll;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // --- directed part ---
      // lookup in an empty table: miss, drop
      send_req(KIND_LOOKUP, 32'h0000_0000, 32'hFFFF_FFFF);
      // address extremes learned, each with the opposite gateway extreme
      send_req(KIND_LEARN,  32'h0000_0000, 32'hFFFF_FFFF);
      send_req(KIND_LEARN,  32'hFFFF_FFFF, 32'h0000_0000);
      send_req(KIND_LOOKUP, 32'h0000_0000, 32'h0000_0000);
      send_req(KIND_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000);
      // learn of a known client overwrites its gateway in place
      send_req(KIND_LEARN,  32'h0000_0000, 32'h5A5A_A5A5);
      send_req(KIND_LOOKUP, 32'h0000_0000, 32'h0000_0000);
      // one bit away from a stored client must miss
      send_req(KIND_LOOKUP, 32'h0000_0001, 32'h0000_0000);
      // fill every remaining entry
      while (known_clients.size() < ENTRIES)
         send_req(KIND_LEARN, fresh_client(), pick_gateway());
      // new client into a full table: flagged, nothing stored
      client = fresh_client();
      send_req(KIND_LEARN,  client, 32'h1234_5678);
      send_req(KIND_LOOKUP, client, 32'h0000_0000);
      // known client while full still overwrites, then reads back
      send_req(KIND_LEARN,  32'hFFFF_FFFF, 32'hC3C3_3C3C);
      send_req(KIND_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000);
      drain();

      // --- random part ---
      // Table stays full from here on: mostly hits and overwrites on stored
      // clients, plus near and far misses and learns refused for lack of room.
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 50 == 0) send_burst = ($urandom_range(0, 3) == 0);
         if (n == RANDOM_ITEMS / 2) drain();
         roll   = $urandom_range(0, 99);
         client = known_clients[$urandom_range(0, known_clients.size() - 1)];
         if (roll < 40)
            send_req(KIND_LOOKUP, client, $urandom);
         else if (roll < 55)
            send_req(KIND_LOOKUP, $urandom_range(0, 1) ?
                     client ^ (32'h1 << $urandom_range(0, 31)) : fresh_client(), $urandom);
         else if (roll < 85)
            send_req(KIND_LEARN, client, pick_gateway());
         else
            send_req(KIND_LEARN, fresh_client(), pick_gateway());
      end
      drain();
      // the block has two stages; let anything stray surface
      repeat (4) @(posedge clock);

      $display("Requests sent: %0d lookups, %0d learns (empty, filling and full table).",
               n_lookup, n_learn);
      $display("Responses checked: %0d, mismatches: %0d, still outstanding: %0d.",
               replies_checked, mismatches, awaited);
      if (mismatches == 0 && awaited == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
